/* rtl/bhr_pkg.sv */
// Shared types, constants and helpers for the brush hue recolor unit.
// No dependencies.
package bhr_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TARGET_HUE   = 3'd0,
    CFG_RECOLOR_MODE = 3'd1,
    CFG_BRUSH_COL    = 3'd2,
    CFG_BRUSH_ROW    = 3'd3,
    CFG_BRUSH_RADIUS = 3'd4,
    CFG_IMAGE_WIDTH  = 3'd5,
    CFG_IMAGE_HEIGHT = 3'd6
  } cfg_idx_t;

  // Hue sectors of 60 degrees each
  typedef enum logic [2:0] {
    SEC_RED     = 3'd0,
    SEC_YELLOW  = 3'd1,
    SEC_GREEN   = 3'd2,
    SEC_CYAN    = 3'd3,
    SEC_BLUE    = 3'd4,
    SEC_MAGENTA = 3'd5
  } sector_t;

  typedef struct packed {
    sector_t    sec;
    logic [5:0] m;
  } hue_t;

  typedef struct packed {
    logic [4:0] r;
    logic [5:0] g;
    logic [4:0] b;
  } rgb565_t;

  // Wraps hue to 0..359 and splits into sector and offset within it.
  function automatic hue_t hue_split(input logic [8:0] hue);
    logic [8:0] h;
    hue_t       res;
    h = (hue >= 9'd360) ? hue - 9'd360 : hue;
    if (h >= 9'd300) begin
      res.sec = SEC_MAGENTA;
      res.m   = 6'(h - 9'd300);
    end else if (h >= 9'd240) begin
      res.sec = SEC_BLUE;
      res.m   = 6'(h - 9'd240);
    end else if (h >= 9'd180) begin
      res.sec = SEC_CYAN;
      res.m   = 6'(h - 9'd180);
    end else if (h >= 9'd120) begin
      res.sec = SEC_GREEN;
      res.m   = 6'(h - 9'd120);
    end else if (h >= 9'd60) begin
      res.sec = SEC_YELLOW;
      res.m   = 6'(h - 9'd60);
    end else begin
      res.sec = SEC_RED;
      res.m   = 6'(h);
    end
    return res;
  endfunction

endpackage

/* rtl/brush_hue_recolor_pixel_unit.sv */
// Throughput one pixel per cycle, set by the fully pipelined saturation
// divider (8 stages) and back conversion (6 stages). busy is always low;
// the receiver cannot stall. Synchronous reset clears the pipeline valids
// and loads the default registers: hue 0, recolor on, center 0/0, radius 0,
// 4096 x 4096 image.
// Depends on bhr_pkg, bhr_disk, bhr_sat, bhr_hsv2rgb.
module brush_hue_recolor_pixel_unit import bhr_pkg::*; #(
  parameter int COORD_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [COORD_BITS-1:0] pix_x,
  input  logic [COORD_BITS-1:0] pix_y,
  input  logic [4:0]            in_red,
  input  logic [5:0]            in_green,
  input  logic [4:0]            in_blue,
  output logic                  done,
  output logic                  write_enable,
  output logic [4:0]            out_red,
  output logic [5:0]            out_green,
  output logic [4:0]            out_blue,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int COLOR_LAT = 16;
  localparam int DISK_LAT  = 3;
  localparam int IN_DLY    = COLOR_LAT - DISK_LAT;

  logic [8:0]            target_hue;
  logic                  recolor_mode;
  logic [COORD_BITS-1:0] brush_col, brush_row;
  logic [7:0]            brush_radius;
  logic [12:0]           image_width, image_height;

  logic       accept;
  rgb565_t    pix_in;
  hue_t       hue;
  logic       inside_d3;
  logic       sat_valid;
  logic [7:0] sat_v, sat_s;
  logic       hsv_valid;
  rgb565_t    hsv_pix;

  rgb565_t pix_dly [0:COLOR_LAT-1];
  logic    in_dly  [0:IN_DLY-1];

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign pix_in    = '{r: in_red, g: in_green, b: in_blue};
  assign hue       = hue_split(target_hue);

  always_ff @(posedge clk) begin
    if (rst) begin
      target_hue   <= 9'd0;
      recolor_mode <= 1'b1;
      brush_col    <= '0;
      brush_row    <= '0;
      brush_radius <= 8'd0;
      image_width  <= 13'd4096;
      image_height <= 13'd4096;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_TARGET_HUE:   target_hue   <= cfg_data[8:0];
        CFG_RECOLOR_MODE: recolor_mode <= cfg_data[0];
        CFG_BRUSH_COL:    brush_col    <= COORD_BITS'(cfg_data[11:0]);
        CFG_BRUSH_ROW:    brush_row    <= COORD_BITS'(cfg_data[11:0]);
        CFG_BRUSH_RADIUS: brush_radius <= cfg_data[7:0];
        CFG_IMAGE_WIDTH:  image_width  <= cfg_data[12:0];
        CFG_IMAGE_HEIGHT: image_height <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  bhr_disk #(.COORD_BITS(COORD_BITS)) u_disk (
    .clk          (clk),
    .pix_x        (pix_x),
    .pix_y        (pix_y),
    .brush_col    (brush_col),
    .brush_row    (brush_row),
    .brush_radius (brush_radius),
    .image_width  (image_width),
    .image_height (image_height),
    .in_disk      (inside_d3)
  );

  bhr_sat u_sat (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept),
    .pix       (pix_in),
    .out_valid (sat_valid),
    .out_v     (sat_v),
    .out_s     (sat_s)
  );

  bhr_hsv2rgb u_hsv (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sat_valid),
    .in_v      (sat_v),
    .in_s      (sat_s),
    .hue       (hue),
    .out_valid (hsv_valid),
    .out_pix   (hsv_pix)
  );

  // original pixel and disk result ride alongside the color pipe
  always_ff @(posedge clk) begin
    pix_dly[0] <= pix_in;
    for (int i = 1; i < COLOR_LAT; i++) pix_dly[i] <= pix_dly[i-1];
    in_dly[0] <= inside_d3;
    for (int i = 1; i < IN_DLY; i++) in_dly[i] <= in_dly[i-1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done         <= 1'b0;
      write_enable <= 1'b0;
      out_red      <= 5'd0;
      out_green    <= 6'd0;
      out_blue     <= 5'd0;
    end else begin
      done         <= hsv_valid;
      write_enable <= hsv_valid && in_dly[IN_DLY-1];
      if (hsv_valid && in_dly[IN_DLY-1]) begin
        out_red   <= recolor_mode ? hsv_pix.r : pix_dly[COLOR_LAT-1].r;
        out_green <= recolor_mode ? hsv_pix.g : pix_dly[COLOR_LAT-1].g;
        out_blue  <= recolor_mode ? hsv_pix.b : pix_dly[COLOR_LAT-1].b;
      end else begin
        out_red   <= 5'd0;
        out_green <= 6'd0;
        out_blue  <= 5'd0;
      end
    end
  end

  a_masked_zero: assert property (@(posedge clk) disable iff (rst)
    done && !write_enable |-> out_red == 5'd0 && out_green == 6'd0 && out_blue == 5'd0)
    else $error("masked pixel carries color");

  a_we_needs_done: assert property (@(posedge clk) disable iff (rst)
    write_enable |-> done)
    else $error("write enable without result beat");

  a_done_follows_pipe: assert property (@(posedge clk) disable iff (rst)
    hsv_valid |=> done)
    else $error("finished pixel not delivered");

endmodule

/* rtl/bhr_disk.sv */
// Brush disk and image bounds test, three register stages.
// Depends on bhr_pkg.
module bhr_disk import bhr_pkg::*; #(
  parameter int COORD_BITS = 12
) (
  input  logic                  clk,
  input  logic [COORD_BITS-1:0] pix_x,
  input  logic [COORD_BITS-1:0] pix_y,
  input  logic [COORD_BITS-1:0] brush_col,
  input  logic [COORD_BITS-1:0] brush_row,
  input  logic [7:0]            brush_radius,
  input  logic [12:0]           image_width,
  input  logic [12:0]           image_height,
  output logic                  in_disk
);

  localparam int CMP_W = (COORD_BITS + 1 > 13) ? COORD_BITS + 1 : 13;
  localparam int SQ_W  = 2 * COORD_BITS;
  localparam int SUM_W = SQ_W + 1;

  logic [COORD_BITS-1:0] dx, dy;
  logic                  in_img;
  logic [SQ_W-1:0]       dx2, dy2;
  logic [15:0]           r2;
  logic                  in_img2;
  logic [SUM_W-1:0]      dsq;

  always_ff @(posedge clk) begin
    dx     <= (pix_x >= brush_col) ? pix_x - brush_col : brush_col - pix_x;
    dy     <= (pix_y >= brush_row) ? pix_y - brush_row : brush_row - pix_y;
    in_img <= (CMP_W'(pix_x) < CMP_W'(image_width)) &&
              (CMP_W'(pix_y) < CMP_W'(image_height));
    r2     <= 16'(brush_radius) * 16'(brush_radius);
  end

  always_ff @(posedge clk) begin
    dx2     <= SQ_W'(dx) * SQ_W'(dx);
    dy2     <= SQ_W'(dy) * SQ_W'(dy);
    in_img2 <= in_img;
  end

  assign dsq = SUM_W'(dx2) + SUM_W'(dy2);

  always_ff @(posedge clk) begin
    in_disk <= in_img2 && (dsq <= SUM_W'(r2));
  end

endmodule

/* rtl/bhr_sat.sv */
// Value and saturation of an RGB565 pixel: max/min, then a one-bit-per-stage
// restoring divider for s. Depends on bhr_pkg.
module bhr_sat import bhr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  rgb565_t    pix,
  output logic       out_valid,
  output logic [7:0] out_v,
  output logic [7:0] out_s
);

  localparam int STEPS = 8;
  localparam int NUM_W = 25;

  logic [7:0] r8, g8, b8, mx, mn;
  logic [7:0] va, mna;
  logic       vlda;
  logic [7:0] d;

  logic [NUM_W-1:0] rem [0:STEPS];
  logic [7:0]       quo [0:STEPS];
  logic [7:0]       vp  [0:STEPS];
  logic             vld [0:STEPS];

  assign r8 = {pix.r, 3'b000};
  assign g8 = {pix.g, 2'b00};
  assign b8 = {pix.b, 3'b000};

  always_comb begin
    mx = r8;
    mn = r8;
    if (g8 > mx) mx = g8;
    if (b8 > mx) mx = b8;
    if (g8 < mn) mn = g8;
    if (b8 < mn) mn = b8;
  end

  always_ff @(posedge clk) begin
    va  <= mx;
    mna <= mn;
    if (rst) vlda <= 1'b0;
    else     vlda <= in_valid;
  end

  assign d = va - mna;

  // numerator of round(d*65535/v) >> 8, over divisor 512*v
  always_ff @(posedge clk) begin
    rem[0] <= NUM_W'(d) * NUM_W'(131070) + NUM_W'(va);
    quo[0] <= 8'd0;
    vp[0]  <= va;
    if (rst) vld[0] <= 1'b0;
    else     vld[0] <= vlda;
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_div
    localparam int SH = 9 + STEPS - 1 - i;
    logic [NUM_W-1:0] dk;
    logic             take;
    assign dk   = NUM_W'(vp[i]) << SH;
    assign take = (vp[i] != 8'd0) && (rem[i] >= dk);
    always_ff @(posedge clk) begin
      rem[i+1] <= take ? rem[i] - dk : rem[i];
      quo[i+1] <= {quo[i][6:0], take};
      vp[i+1]  <= vp[i];
      if (rst) vld[i+1] <= 1'b0;
      else     vld[i+1] <= vld[i];
    end
  end

  assign out_valid = vld[STEPS];
  assign out_v     = vp[STEPS];
  assign out_s     = quo[STEPS];

  a_black_no_sat: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_v == 8'd0 |-> out_s == 8'd0)
    else $error("saturation nonzero for black pixel");

endmodule

/* rtl/bhr_hsv2rgb.sv */
// HSV to RGB565 back conversion, six register stages, constant divisions
// by reciprocal multiply with one correction step. Depends on bhr_pkg.
module bhr_hsv2rgb import bhr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [7:0] in_v,
  input  logic [7:0] in_s,
  input  hue_t       hue,
  output logic       out_valid,
  output rgb565_t    out_pix
);

  localparam int XP_W = 25;
  localparam int XQ_W = 31;
  localparam logic [16:0] KP = 17'd65793;  // floor(2^25 / 510)
  localparam logic [16:0] KQ = 17'd70179;  // floor(2^31 / 30600)

  // stage 1
  logic [7:0]  v1;
  logic        g1, vld1;
  logic [15:0] a1;
  logic [13:0] sm1, st1;
  // stage 2
  logic [7:0]  v2;
  logic        g2, vld2;
  logic [13:0] cq, ct;
  logic [21:0] vq2, vt2;
  logic [XP_W-1:0] xp2;
  // stage 3
  logic [7:0]  v3;
  logic        g3, vld3;
  logic [XP_W-1:0] xp3;
  logic [XQ_W-1:0] xq3, xt3;
  // stage 4
  logic [7:0]  v4;
  logic        g4, vld4;
  logic [XP_W-1:0] xp4;
  logic [XQ_W-1:0] xq4, xt4;
  logic [41:0] pp;
  logic [47:0] pq, pt;
  logic [15:0] qp4, qq4, qt4;
  // stage 5
  logic [7:0]  v5;
  logic        g5, vld5;
  logic [XP_W-1:0] rp;
  logic [XQ_W-1:0] rq, rt;
  logic [15:0] p5, q5, t5;
  // stage 6
  logic [7:0]  r8, gg8, b8;

  always_ff @(posedge clk) begin
    v1  <= in_v;
    g1  <= (in_s == 8'd0);
    a1  <= 16'(in_v) * 16'(8'd255 - in_s);
    sm1 <= 14'(in_s) * 14'(hue.m);
    st1 <= 14'(in_s) * 14'(6'd60 - hue.m);
    if (rst) vld1 <= 1'b0;
    else     vld1 <= in_valid;
  end

  assign cq = 14'd15300 - sm1;
  assign ct = 14'd15300 - st1;

  always_ff @(posedge clk) begin
    v2  <= v1;
    g2  <= g1;
    vq2 <= 22'(v1) * 22'(cq);
    vt2 <= 22'(v1) * 22'(ct);
    xp2 <= XP_W'(a1) * XP_W'(514) + XP_W'(255);
    if (rst) vld2 <= 1'b0;
    else     vld2 <= vld1;
  end

  always_ff @(posedge clk) begin
    v3  <= v2;
    g3  <= g2;
    xp3 <= xp2;
    xq3 <= XQ_W'(vq2) * XQ_W'(514) + XQ_W'(15300);
    xt3 <= XQ_W'(vt2) * XQ_W'(514) + XQ_W'(15300);
    if (rst) vld3 <= 1'b0;
    else     vld3 <= vld2;
  end

  assign pp = 42'(xp3) * 42'(KP);
  assign pq = 48'(xq3) * 48'(KQ);
  assign pt = 48'(xt3) * 48'(KQ);

  always_ff @(posedge clk) begin
    v4  <= v3;
    g4  <= g3;
    xp4 <= xp3;
    xq4 <= xq3;
    xt4 <= xt3;
    qp4 <= pp[40:25];
    qq4 <= pq[46:31];
    qt4 <= pt[46:31];
    if (rst) vld4 <= 1'b0;
    else     vld4 <= vld3;
  end

  // estimate is low by at most one
  assign rp = xp4 - XP_W'(XP_W'(qp4) * XP_W'(510));
  assign rq = xq4 - XQ_W'(XQ_W'(qq4) * XQ_W'(30600));
  assign rt = xt4 - XQ_W'(XQ_W'(qt4) * XQ_W'(30600));

  always_ff @(posedge clk) begin
    v5 <= v4;
    g5 <= g4;
    p5 <= qp4 + 16'(rp >= XP_W'(510));
    q5 <= qq4 + 16'(rq >= XQ_W'(30600));
    t5 <= qt4 + 16'(rt >= XQ_W'(30600));
    if (rst) vld5 <= 1'b0;
    else     vld5 <= vld4;
  end

  // 257*v >> 8 is v itself
  always_comb begin
    case (hue.sec)
      SEC_RED:    begin r8 = v5;        gg8 = t5[15:8]; b8 = p5[15:8]; end
      SEC_YELLOW: begin r8 = q5[15:8];  gg8 = v5;       b8 = p5[15:8]; end
      SEC_GREEN:  begin r8 = p5[15:8];  gg8 = v5;       b8 = t5[15:8]; end
      SEC_CYAN:   begin r8 = p5[15:8];  gg8 = q5[15:8]; b8 = v5;       end
      SEC_BLUE:   begin r8 = t5[15:8];  gg8 = p5[15:8]; b8 = v5;       end
      default:    begin r8 = v5;        gg8 = p5[15:8]; b8 = q5[15:8]; end
    endcase
    if (g5) begin
      r8  = v5;
      gg8 = v5;
      b8  = v5;
    end
  end

  always_ff @(posedge clk) begin
    out_pix.r <= r8[7:3];
    out_pix.g <= gg8[7:2];
    out_pix.b <= b8[7:3];
    if (rst) out_valid <= 1'b0;
    else     out_valid <= vld5;
  end

  a_p_corr: assert property (@(posedge clk) disable iff (rst)
    vld4 |-> rp < XP_W'(1020))
    else $error("p reciprocal estimate off by more than one");

  a_q_corr: assert property (@(posedge clk) disable iff (rst)
    vld4 |-> rq < XQ_W'(61200) && rt < XQ_W'(61200))
    else $error("q/t reciprocal estimate off by more than one");

endmodule
